FILE: hdl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared sizes, codes, result record and ring index helpers for the stable
// priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEPTH          = 16;
    localparam int PRIORITY_WIDTH = 8;
    localparam int PAYLOAD_WIDTH  = 32;

    localparam int IDX_W    = $clog2(DEPTH);
    localparam int LEN_W    = $clog2(DEPTH + 1);
    localparam int SUM_W    = LEN_W + 1;
    localparam int CFG_W    = 5;
    localparam int ENTRY_W  = PRIORITY_WIDTH + PAYLOAD_WIDTH;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_POP    = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE          = 2'd0,
        ST_REFUSED_FULL  = 2'd1,
        ST_REFUSED_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        t_status                   status;
        logic [PAYLOAD_WIDTH-1:0]  payload;
        logic [PRIORITY_WIDTH-1:0] prio;
        logic                      empty;
        logic                      full;
    } t_result;

    // (base + off) mod len, with base < len and off <= len
    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                  input logic [LEN_W-1:0] off,
                                                  input logic [LEN_W-1:0] len);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(len)) begin
            sum = sum - SUM_W'(len);
        end
        return sum[IDX_W-1:0];
    endfunction

    // (a - b) mod len, with a, b < len
    function automatic logic [LEN_W-1:0] wrap_dist(input logic [IDX_W-1:0] a,
                                                   input logic [IDX_W-1:0] b,
                                                   input logic [LEN_W-1:0] len);
        logic [SUM_W-1:0] d;
        if (a >= b) begin
            d = SUM_W'(a) - SUM_W'(b);
        end else begin
            d = SUM_W'(a) + SUM_W'(len) - SUM_W'(b);
        end
        return d[LEN_W-1:0];
    endfunction

    function automatic logic [LEN_W-1:0] held_count(input logic [IDX_W-1:0] head,
                                                    input logic [IDX_W-1:0] tail,
                                                    input logic             full,
                                                    input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] cnt;
        if (full) begin
            cnt = len;
        end else begin
            cnt = wrap_dist(tail, head, len);
        end
        return cnt;
    endfunction

    // zero reads as one, anything above the built depth as the depth
    function automatic logic [LEN_W-1:0] clamp_len(input logic [CFG_W-1:0] v);
        logic [LEN_W-1:0] len;
        if (v == '0) begin
            len = LEN_W'(1);
        end else if (32'(v) > 32'(DEPTH)) begin
            len = LEN_W'(DEPTH);
        end else begin
            len = LEN_W'(v);
        end
        return len;
    endfunction

endpackage

FILE: hdl/stable_priority_queue.sv
// ----------------------------------------------------------------------------
// stable_priority_queue
// Fixed-depth stable priority queue held in one ring RAM, sorted lazily
// by insertion sort before each pop.
// ----------------------------------------------------------------------------
// Items enter on the in channel (valid/ready): command 0 inserts a priority
// and payload at the tail, command 1 pops the highest priority entry, the
// oldest first among equal priorities. Each item yields one result on the
// out channel (valid/ready) with a status, the popped entry or zeros, and
// the empty and full flags after the item.
// An insert or a refused pop is handled in the idle state; its result is in
// the result buffer on the next cycle. A pop first places every entry
// inserted since the last sort: it loads and fetches the entry, then steps
// it past each lower entry of the sorted run and writes it into place, and
// only then reads the head. The sort time is set by the single RAM read
// port, one read, compare and write-back per cycle.
// A two-entry result buffer lets one new item be taken while a result waits;
// when the receiver stalls longer, ready drops until the receiver takes a
// result. Reset empties the queue and sets length_in_use to the built depth;
// a write of length_in_use also empties the queue. No clearing pass is run.
// ----------------------------------------------------------------------------
module stable_priority_queue (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [spq_pkg::CFG_W-1:0]          i_cfg_wdata,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_command,
    input  logic [spq_pkg::PRIORITY_WIDTH-1:0] i_priority_req,
    input  logic [spq_pkg::PAYLOAD_WIDTH-1:0]  i_payload_in,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [1:0]                         o_status,
    output logic [spq_pkg::PAYLOAD_WIDTH-1:0]  o_payload_out,
    output logic [spq_pkg::PRIORITY_WIDTH-1:0] o_priority_out,
    output logic                               o_now_empty,
    output logic                               o_now_full
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_LOAD     = 7'b0000010,
        S_FETCH    = 7'b0000100,
        S_STEP     = 7'b0001000,
        S_PLACE    = 7'b0010000,
        S_POP_RD   = 7'b0100000,
        S_POP_DATA = 7'b1000000
    } t_state;

    localparam int PW = spq_pkg::PRIORITY_WIDTH;
    localparam int DW = spq_pkg::PAYLOAD_WIDTH;
    localparam int EW = spq_pkg::ENTRY_W;
    localparam int IW = spq_pkg::IDX_W;
    localparam int LW = spq_pkg::LEN_W;

    t_state             r_state, n_state;
    logic [LW-1:0]      r_len;
    logic [IW-1:0]      r_head, n_head;
    logic [IW-1:0]      r_tail, n_tail;
    logic               r_full, n_full;
    logic [IW-1:0]      r_sorted_end, n_sorted_end;
    logic [LW-1:0]      r_count, n_count;
    logic [LW-1:0]      r_run, n_run;
    logic [LW-1:0]      r_j, n_j;
    logic [EW-1:0]      r_new, n_new;

    logic               in_fire;
    logic               room;
    logic               push;
    spq_pkg::t_result   res;
    spq_pkg::t_result   out_data;
    logic               we;
    logic [IW-1:0]      waddr;
    logic [EW-1:0]      wdata;
    logic [IW-1:0]      raddr;
    logic [EW-1:0]      rdata;
    logic [LW-1:0]      held;
    logic [LW-1:0]      run_now;
    logic [IW-1:0]      tail_inc;
    logic [IW-1:0]      head_inc;
    logic [PW-1:0]      rd_prio;
    logic [PW-1:0]      new_prio;
    logic               entry_done;

    assign o_in_ready = (r_state == S_IDLE) && room;
    assign in_fire    = i_in_valid && o_in_ready;

    assign held     = spq_pkg::held_count(r_head, r_tail, r_full, r_len);
    assign run_now  = spq_pkg::wrap_dist(r_sorted_end, r_head, r_len) + LW'(1);
    assign tail_inc = spq_pkg::wrap_add(r_tail, LW'(1), r_len);
    assign head_inc = spq_pkg::wrap_add(r_head, LW'(1), r_len);
    assign rd_prio  = rdata[EW-1 -: PW];
    assign new_prio = r_new[EW-1 -: PW];

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_tail       = r_tail;
        n_full       = r_full;
        n_sorted_end = r_sorted_end;
        n_count      = r_count;
        n_run        = r_run;
        n_j          = r_j;
        n_new        = r_new;
        push         = 1'b0;
        res          = '0;
        we           = 1'b0;
        waddr        = r_tail;
        wdata        = {i_priority_req, i_payload_in};
        raddr        = r_head;
        entry_done   = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_command == spq_pkg::CMD_INSERT) begin
                        push = 1'b1;
                        if (r_full) begin
                            res.status = spq_pkg::ST_REFUSED_FULL;
                            res.full   = 1'b1;
                        end else begin
                            we = 1'b1;
                            if (held == '0) begin
                                n_sorted_end = r_tail;
                            end
                            n_tail     = tail_inc;
                            n_full     = (tail_inc == r_head);
                            res.status = spq_pkg::ST_DONE;
                            res.full   = (tail_inc == r_head);
                        end
                    end else begin
                        if (held == '0) begin
                            push       = 1'b1;
                            res.status = spq_pkg::ST_REFUSED_EMPTY;
                            res.empty  = 1'b1;
                        end else begin
                            n_count = held;
                            n_run   = run_now;
                            n_state = (run_now < held) ? S_LOAD : S_POP_RD;
                        end
                    end
                end
            end
            S_LOAD: begin
                raddr   = spq_pkg::wrap_add(r_head, r_run, r_len);
                n_state = S_FETCH;
            end
            S_FETCH: begin
                // new entry arrives, start reading the run from its end
                n_new   = rdata;
                raddr   = spq_pkg::wrap_add(r_head, r_run - LW'(1), r_len);
                n_j     = r_run;
                n_state = S_STEP;
            end
            S_STEP: begin
                we    = 1'b1;
                waddr = spq_pkg::wrap_add(r_head, r_j, r_len);
                if (rd_prio >= new_prio) begin
                    wdata      = r_new;
                    entry_done = 1'b1;
                end else begin
                    // shift the lower entry up one slot
                    wdata = rdata;
                    n_j   = r_j - LW'(1);
                    if (r_j == LW'(1)) begin
                        n_state = S_PLACE;
                    end else begin
                        raddr = spq_pkg::wrap_add(r_head, r_j - LW'(2), r_len);
                    end
                end
            end
            S_PLACE: begin
                we         = 1'b1;
                waddr      = r_head;
                wdata      = r_new;
                entry_done = 1'b1;
            end
            S_POP_RD: begin
                raddr   = r_head;
                n_state = S_POP_DATA;
            end
            S_POP_DATA: begin
                push         = 1'b1;
                res.status   = spq_pkg::ST_DONE;
                res.payload  = rdata[DW-1:0];
                res.prio     = rd_prio;
                res.empty    = (r_count == LW'(1));
                n_head       = head_inc;
                n_full       = 1'b0;
                n_sorted_end = spq_pkg::wrap_add(r_head, r_count - LW'(1), r_len);
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (entry_done) begin
            n_run   = r_run + LW'(1);
            n_state = ((r_run + LW'(1)) < r_count) ? S_LOAD : S_POP_RD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_len        <= LW'(spq_pkg::DEPTH);
            r_head       <= '0;
            r_tail       <= '0;
            r_full       <= 1'b0;
            r_sorted_end <= '0;
            r_count      <= '0;
            r_run        <= '0;
            r_j          <= '0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_run        <= n_run;
            r_j          <= n_j;
            if (i_cfg_we) begin
                r_len        <= spq_pkg::clamp_len(i_cfg_wdata);
                r_head       <= '0;
                r_tail       <= '0;
                r_full       <= 1'b0;
                r_sorted_end <= '0;
            end else begin
                r_head       <= n_head;
                r_tail       <= n_tail;
                r_full       <= n_full;
                r_sorted_end <= n_sorted_end;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_new <= n_new;
    end

    spq_ram #(
        .WIDTH (spq_pkg::ENTRY_W),
        .DEPTH (spq_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    spq_rbuf u_rbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (res),
        .o_room  (room),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (out_data)
    );

    assign o_status       = out_data.status;
    assign o_payload_out  = out_data.payload;
    assign o_priority_out = out_data.prio;
    assign o_now_empty    = out_data.empty;
    assign o_now_full     = out_data.full;

    // a result is only produced when the buffer can take it
    assert property (@(posedge i_clk) disable iff (!i_rst_n) push |-> room)
        else $error("result pushed into a full buffer");

    // full queue means the ring pointers meet
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_full |-> (r_tail == r_head))
        else $error("full flag set with head and tail apart");

    // ring pointers stay inside the slots in use
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (LW'(r_head) < r_len) && (LW'(r_tail) < r_len))
        else $error("ring pointer beyond length in use");

    // a sort pass only starts while unsorted entries remain
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |-> (r_run < r_count))
        else $error("sort pass past the held entries");

endmodule

FILE: hdl/spq_ram.sv
// ----------------------------------------------------------------------------
// spq_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data (old data on collision).
// ----------------------------------------------------------------------------
module spq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/spq_rbuf.sv
// ----------------------------------------------------------------------------
// spq_rbuf
// Two-entry result buffer between the sequencer and the output channel,
// so a new item can be taken while a finished result waits.
// ----------------------------------------------------------------------------
module spq_rbuf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  spq_pkg::t_result i_data,
    output logic             o_room,
    output logic             o_valid,
    input  logic             i_ready,
    output spq_pkg::t_result o_data
);

    spq_pkg::t_result r_slot0;
    spq_pkg::t_result r_slot1;
    logic             r_v0;
    logic             r_v1;
    logic             pop;

    assign pop     = r_v0 && i_ready;
    assign o_valid = r_v0;
    assign o_data  = r_slot0;
    assign o_room  = !r_v1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            if (pop) begin
                if (r_v1) begin
                    r_slot0 <= r_slot1;
                    if (i_push) begin
                        r_slot1 <= i_data;
                    end
                    r_v1 <= i_push;
                end else begin
                    if (i_push) begin
                        r_slot0 <= i_data;
                    end
                    r_v0 <= i_push;
                end
            end else if (i_push) begin
                if (!r_v0) begin
                    r_slot0 <= i_data;
                    r_v0    <= 1'b1;
                end else begin
                    r_slot1 <= i_data;
                    r_v1    <= 1'b1;
                end
            end
        end
    end

endmodule

FILE: verif/stable_priority_queue_test.sv
// ----------------------------------------------------------------------------
// stable_priority_queue_test
// Self-checking testbench for the stable priority queue. Each accepted
// command is run through a shadow queue that keeps entries in arrival order
// and pops the first entry of the highest priority. Every returned result is
// compared field by field against the oldest prediction. Directed cases
// cover priority and payload extremes, ties, refusals and the length
// register. They are followed by a long output stall that backs up the
// input, and by random traffic under several lengths and idle patterns.
// ----------------------------------------------------------------------------
module stable_priority_queue_test;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    typedef struct packed {
        logic [PRIORITY_WIDTH-1:0] prio;
        logic [PAYLOAD_WIDTH-1:0]  payload;
    } t_entry;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [CFG_W-1:0]          i_cfg_wdata;
    logic                      i_in_valid;
    logic                      o_in_ready;
    logic                      i_command;
    logic [PRIORITY_WIDTH-1:0] i_priority_req;
    logic [PAYLOAD_WIDTH-1:0]  i_payload_in;
    logic                      o_out_valid;
    logic                      i_out_ready;
    logic [1:0]                o_status;
    logic [PAYLOAD_WIDTH-1:0]  o_payload_out;
    logic [PRIORITY_WIDTH-1:0] o_priority_out;
    logic                      o_now_empty;
    logic                      o_now_full;

    // shadow of the queue contents in arrival order
    t_entry  shadow_entries[$];
    int      shadow_length = DEPTH;
    t_result awaited_results[$];

    int error_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;

    stable_priority_queue uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_priority_req (i_priority_req),
        .i_payload_in   (i_payload_in),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_payload_out  (o_payload_out),
        .o_priority_out (o_priority_out),
        .o_now_empty    (o_now_empty),
        .o_now_full     (o_now_full)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------
    function automatic t_result predict_queue_op(input logic cmd,
                                                 input logic [PRIORITY_WIDTH-1:0] prio,
                                                 input logic [PAYLOAD_WIDTH-1:0] pay);
        t_result r;
        t_entry  e;
        int      best;
        r = '0;
        r.status = ST_DONE;
        if (cmd == CMD_INSERT) begin
            if (shadow_entries.size() >= shadow_length) begin
                r.status = ST_REFUSED_FULL;
            end else begin
                e.prio    = prio;
                e.payload = pay;
                shadow_entries.push_back(e);
            end
        end else begin
            if (shadow_entries.size() == 0) begin
                r.status = ST_REFUSED_EMPTY;
            end else begin
                // strict compare keeps the oldest among equal priorities
                best = 0;
                for (int i = 1; i < shadow_entries.size(); i++) begin
                    if (shadow_entries[i].prio > shadow_entries[best].prio) begin
                        best = i;
                    end
                end
                r.payload = shadow_entries[best].payload;
                r.prio    = shadow_entries[best].prio;
                shadow_entries.delete(best);
            end
        end
        r.empty = (shadow_entries.size() == 0);
        r.full  = (shadow_entries.size() == shadow_length);
        return r;
    endfunction

    function automatic void predict_length_write(input logic [CFG_W-1:0] v);
        if (v == '0) begin
            shadow_length = 1;
        end else if (int'(v) > DEPTH) begin
            shadow_length = DEPTH;
        end else begin
            shadow_length = int'(v);
        end
        shadow_entries.delete();
    endfunction

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    endtask

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("result with none pending", 64'(o_status), 64'(0));
            end else begin
                want = awaited_results.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", 64'(o_status), 64'(want.status));
                if (o_payload_out !== want.payload)
                    report_mismatch("payload_out", 64'(o_payload_out), 64'(want.payload));
                if (o_priority_out !== want.prio)
                    report_mismatch("priority_out", 64'(o_priority_out), 64'(want.prio));
                if (o_now_empty !== want.empty)
                    report_mismatch("now_empty", 64'(o_now_empty), 64'(want.empty));
                if (o_now_full !== want.full)
                    report_mismatch("now_full", 64'(o_now_full), 64'(want.full));
            end
        end
    end

    // output side: random stalls, or a long hold-off when one is requested
    initial begin : drive_out_ready
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_out_ready <= 1'b0;
                hold_left--;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers, all entered and left at a falling edge
    // ------------------------------------------------------------------------
    // valid stays high on return so back-to-back transfers need no gap
    task automatic send_item(input logic cmd, input logic [PRIORITY_WIDTH-1:0] prio,
                             input logic [PAYLOAD_WIDTH-1:0] pay);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_command      <= cmd;
        i_priority_req <= prio;
        i_payload_in   <= pay;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) @(posedge i_clk);
        awaited_results.push_back(predict_queue_op(cmd, prio, pay));
        @(negedge i_clk);
    endtask

    task automatic insert(input logic [PRIORITY_WIDTH-1:0] prio,
                          input logic [PAYLOAD_WIDTH-1:0] pay);
        send_item(CMD_INSERT, prio, pay);
    endtask

    task automatic pop();
        send_item(CMD_POP, PRIORITY_WIDTH'($urandom), $urandom);
    endtask

    task automatic wait_until_idle();
        i_in_valid <= 1'b0;
        while (awaited_results.size() != 0) @(negedge i_clk);
        // settle after the last result
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_length(input logic [CFG_W-1:0] v);
        wait_until_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        predict_length_write(v);
    endtask

    task automatic set_idling(input t_idle_mode mode);
        case (mode)
            IDLE_SENDER: begin
                send_idle_pct  = 54;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                send_idle_pct  = 0;
                recv_stall_pct = 54;
            end
            IDLE_BOTH: begin
                send_idle_pct  = 28;
                recv_stall_pct = 28;
            end
            default: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
        endcase
    endtask

    function automatic logic [PRIORITY_WIDTH-1:0] random_priority();
        int pick;
        pick = $urandom_range(9);
        if (pick < 4) return PRIORITY_WIDTH'($urandom_range(3));  // many ties
        if (pick == 4) return '1;
        if (pick == 5) return '0;
        return PRIORITY_WIDTH'($urandom);
    endfunction

    // bursts that lean toward inserts fill the queue, the others drain it
    task automatic run_phase(input int count, input logic [CFG_W-1:0] length_value,
                             input t_idle_mode mode);
        int insert_pct;
        write_length(length_value);
        set_idling(mode);
        insert_pct = 50;
        for (int n = 0; n < count; n++) begin
            if (n % 24 == 0) insert_pct = $urandom_range(1) ? 80 : 25;
            if ($urandom_range(99) < insert_pct) insert(random_priority(), $urandom);
            else pop();
        end
        wait_until_idle();
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_reset_state();
        pop();
        insert('0, '0);
        wait_until_idle();
    endtask

    task automatic test_priority_order();
        insert('1, '1);
        insert('1, 32'h0000_0001);
        insert(8'd128, 32'h5a5a_5a5a);
        pop();
        pop();
        // a lowest entry after a sorted run, and a new top entry
        insert('0, 32'h0000_0002);
        insert('1, 32'h0000_0003);
        pop();
        pop();
        pop();
        pop();
        pop();
        wait_until_idle();
    endtask

    task automatic test_minimum_length();
        write_length(5'd0);
        insert(8'd7, 32'ha5a5_0001);
        insert(8'd9, 32'ha5a5_0002);
        pop();
        pop();
        wait_until_idle();
    endtask

    task automatic test_short_full_queue();
        write_length(5'd3);
        insert(8'd5, 32'h1111_1111);
        insert(8'd9, 32'h2222_2222);
        insert(8'd5, 32'h3333_3333);
        insert(8'd200, 32'h4444_4444);
        pop();
        pop();
        pop();
        wait_until_idle();
    endtask

    task automatic test_input_backpressure();
        write_length(5'd16);
        set_idling(IDLE_NONE);
        @(posedge i_clk);
        hold_left = 300;
        @(negedge i_clk);
        for (int n = 0; n < 20; n++) insert(random_priority(), $urandom);
        for (int n = 0; n < 20; n++) pop();
        wait_until_idle();
    endtask

    task automatic test_random_traffic();
        run_phase(300, 5'd31, IDLE_NONE);
        run_phase(250, 5'd4, IDLE_SENDER);
        run_phase(150, 5'd1, IDLE_RECEIVER);
        run_phase(300, 5'd17, IDLE_BOTH);
        run_phase(300, CFG_W'($urandom_range(15, 2)), IDLE_NONE);
        run_phase(300, 5'd16, IDLE_RECEIVER);
        run_phase(250, 5'd8, IDLE_SENDER);
    endtask

    initial begin : run_tests
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        i_in_valid     = 1'b0;
        i_command      = CMD_INSERT;
        i_priority_req = '0;
        i_payload_in   = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_state();
        test_priority_order();
        test_minimum_length();
        test_short_full_queue();
        test_input_backpressure();
        test_random_traffic();

        wait_until_idle();
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
